// ===== hw/rtl/dagr_pkg.sv =====
// Shared types and constants for the digital axis with gravity return.
`timescale 1ns / 1ps

package dagr_pkg;

    localparam int KEY_W     = 2;
    localparam int DT_W      = 16;
    localparam int VALUE_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int GRAVITY_W = 8;
    localparam int DZONE_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Full scale in Q2.14
    localparam logic signed [VALUE_W-1:0] AXIS_POS_ONE = 16'sd16384;
    localparam logic signed [VALUE_W-1:0] AXIS_NEG_ONE = -16'sd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_KEY_BOUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_KEY_BOUND = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEUTRAL      = 3'd0,
        ST_NEG_PRESSED  = 3'd1,
        ST_POS_PRESSED  = 3'd2,
        ST_NEG_REPEATED = 3'd3,
        ST_POS_REPEATED = 3'd4,
        ST_RELEASED     = 3'd5
    } axis_status_t;

    typedef enum logic [KEY_W-1:0] {
        LVL_NONE     = 2'd0,
        LVL_PRESSED  = 2'd1,
        LVL_RELEASED = 2'd2,
        LVL_REPEATED = 2'd3
    } key_level_t;

    typedef struct packed {
        logic [GRAVITY_W-1:0] gravity_rate;
        logic [DZONE_W-1:0]   zero_band;
        logic                 stick_mode;
        logic                 neg_key_bound;
        logic                 pos_key_bound;
    } cfg_t;

    typedef struct packed {
        key_level_t          neg_key_state;
        key_level_t          pos_key_state;
        logic [DT_W-1:0]     delta_time;
    } tick_t;

    typedef struct packed {
        axis_status_t               status;
        logic signed [VALUE_W-1:0]  value;
        logic                       signal_sent;
    } axis_state_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  axis_value;
        axis_status_t               axis_status;
        logic                       pressed_flag;
        logic                       released_flag;
    } result_t;

endpackage

// ===== hw/rtl/digital_axis_with_gravity_return.sv =====
// An accepted input is held in the input register; its result then goes to the
// output register, which drives m_tvalid. Throughput: one tick per cycle while
// m_tready is high; the input register feeds a single level of tick logic (one
// 8x16 multiply, one add and compare) into the output register.
// Reset: synchronous, active low; status neutral, value zero, one-shot latch
// clear, gravity and zero band zero, stick mode off, both keys bound.
`timescale 1ns / 1ps

module digital_axis_with_gravity_return
    import dagr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: neg_key_state[1:0], pos_key_state[3:2], delta_time[19:4], zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: axis_value[15:0], axis_status[18:16], pressed_flag[19],
    //          released_flag[20], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_data
);

    cfg_t        cfg;
    tick_t       tick_reg;
    tick_t       tick_next;
    logic        in_valid_reg;
    logic        in_valid_next;
    axis_state_t state_reg;
    axis_state_t state_next;
    axis_state_t tick_state;
    result_t     tick_result;
    result_t     out_reg;
    result_t     out_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        s_xfer;
    logic        advance;

    dagr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dagr_tick u_tick (
        .cfg    (cfg),
        .tick   (tick_reg),
        .cur    (state_reg),
        .nxt    (tick_state),
        .result (tick_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        tick_next      = tick_reg;
        in_valid_next  = in_valid_reg;
        state_next     = state_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            in_valid_next  = 1'b0;
            state_next     = tick_state;
            out_next       = tick_result;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s_xfer) begin
            tick_next.neg_key_state = key_level_t'(s_tdata[1:0]);
            tick_next.pos_key_state = key_level_t'(s_tdata[3:2]);
            tick_next.delta_time    = s_tdata[19:4];
            in_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.status      <= ST_NEUTRAL;
            state_reg.value       <= '0;
            state_reg.signal_sent <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        tick_reg <= tick_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.released_flag, out_reg.pressed_flag,
                       out_reg.axis_status, out_reg.axis_value};

endmodule

// ===== hw/rtl/dagr_cfg_regs.sv =====
// Configuration register file for the axis block.
`timescale 1ns / 1ps

module dagr_cfg_regs
    import dagr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GRAVITY_RATE:  cfg_next.gravity_rate  = cfg_data[GRAVITY_W-1:0];
                CFG_ZERO_BAND:     cfg_next.zero_band     = cfg_data[DZONE_W-1:0];
                CFG_STICK_MODE:    cfg_next.stick_mode    = cfg_data[0];
                CFG_NEG_KEY_BOUND: cfg_next.neg_key_bound = cfg_data[0];
                CFG_POS_KEY_BOUND: cfg_next.pos_key_bound = cfg_data[0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gravity_rate  <= '0;
            cfg_reg.zero_band     <= '0;
            cfg_reg.stick_mode    <= 1'b0;
            cfg_reg.neg_key_bound <= 1'b1;
            cfg_reg.pos_key_bound <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/dagr_tick.sv =====
// Per-tick next-state logic: status machine, gravity decay and queries.
`timescale 1ns / 1ps

module dagr_tick
    import dagr_pkg::*;
(
    input  cfg_t        cfg,
    input  tick_t       tick,
    input  axis_state_t cur,
    output axis_state_t nxt,
    output result_t     result
);

    localparam int PROD_W = GRAVITY_W + DT_W;
    localparam int DEC_W  = PROD_W - 2;
    localparam int CMP_W  = PROD_W;

    logic [PROD_W-1:0]       product;
    logic [DEC_W-1:0]        decrement;
    logic signed [CMP_W-1:0] value_ext;
    logic signed [CMP_W-1:0] dec_ext;
    logic signed [CMP_W-1:0] dz_ext;
    logic signed [CMP_W-1:0] grav_sum;
    logic                    grav_snap;
    logic signed [VALUE_W-1:0] grav_value;
    logic                    neg_press;
    logic                    pos_press;

    // Gravity step, computed from the current value every tick
    always_comb begin
        product   = PROD_W'(cfg.gravity_rate) * PROD_W'(tick.delta_time);
        decrement = product[PROD_W-1:2];
        value_ext = CMP_W'(cur.value);
        dec_ext   = $signed({2'b00, decrement});
        dz_ext    = $signed({{(CMP_W-DZONE_W){1'b0}}, cfg.zero_band});
        if (cur.value < 0) begin
            grav_sum  = value_ext + dec_ext;
            grav_snap = (grav_sum >= -dz_ext);
        end else begin
            grav_sum  = value_ext - dec_ext;
            grav_snap = (grav_sum <= dz_ext);
        end
        // outside the zero band the sum stays within full scale
        grav_value = grav_snap ? '0 : grav_sum[VALUE_W-1:0];
    end

    assign neg_press = cfg.neg_key_bound && (tick.neg_key_state == LVL_PRESSED);
    assign pos_press = cfg.pos_key_bound && (tick.pos_key_state == LVL_PRESSED);

    always_comb begin
        nxt = cur;
        unique case (cur.status)
            ST_RELEASED: begin
                nxt.value       = grav_value;
                nxt.status      = grav_snap ? ST_NEUTRAL : ST_RELEASED;
                nxt.signal_sent = 1'b0;
                if (neg_press) begin
                    nxt.status = ST_NEG_PRESSED;
                    nxt.value  = AXIS_NEG_ONE;
                end else if (pos_press) begin
                    nxt.status = ST_POS_PRESSED;
                    nxt.value  = AXIS_POS_ONE;
                end
            end
            ST_NEUTRAL: begin
                if (neg_press) begin
                    nxt.status = ST_NEG_PRESSED;
                    nxt.value  = AXIS_NEG_ONE;
                end else if (pos_press) begin
                    nxt.status = ST_POS_PRESSED;
                    nxt.value  = AXIS_POS_ONE;
                end
            end
            ST_NEG_PRESSED: begin
                if (pos_press) begin
                    nxt.status = ST_POS_PRESSED;
                    nxt.value  = AXIS_POS_ONE;
                end else if (cfg.neg_key_bound) begin
                    if (cfg.stick_mode && tick.neg_key_state == LVL_REPEATED) begin
                        nxt.status = ST_NEG_REPEATED;
                        nxt.value  = AXIS_NEG_ONE;
                    end else if (tick.neg_key_state == LVL_RELEASED) begin
                        nxt.value       = grav_value;
                        nxt.status      = grav_snap ? ST_NEUTRAL : ST_RELEASED;
                        nxt.signal_sent = 1'b0;
                    end
                end
            end
            ST_POS_PRESSED: begin
                if (neg_press) begin
                    nxt.status = ST_NEG_PRESSED;
                    nxt.value  = AXIS_NEG_ONE;
                end else if (cfg.pos_key_bound) begin
                    if (cfg.stick_mode && tick.pos_key_state == LVL_REPEATED) begin
                        nxt.status = ST_POS_REPEATED;
                        nxt.value  = AXIS_POS_ONE;
                    end else if (tick.pos_key_state == LVL_RELEASED) begin
                        nxt.value       = grav_value;
                        nxt.status      = grav_snap ? ST_NEUTRAL : ST_RELEASED;
                        nxt.signal_sent = 1'b0;
                    end
                end
            end
            ST_POS_REPEATED: begin
                if (neg_press) begin
                    nxt.status = ST_NEG_PRESSED;
                    nxt.value  = AXIS_NEG_ONE;
                end else if (cfg.pos_key_bound && tick.pos_key_state == LVL_RELEASED) begin
                    nxt.value       = grav_value;
                    nxt.status      = grav_snap ? ST_NEUTRAL : ST_RELEASED;
                    nxt.signal_sent = 1'b0;
                end
            end
            ST_NEG_REPEATED: begin
                if (pos_press) begin
                    nxt.status = ST_POS_PRESSED;
                    nxt.value  = AXIS_POS_ONE;
                end else if (cfg.neg_key_bound && tick.neg_key_state == LVL_RELEASED) begin
                    nxt.value       = grav_value;
                    nxt.status      = grav_snap ? ST_NEUTRAL : ST_RELEASED;
                    nxt.signal_sent = 1'b0;
                end
            end
            default: ;
        endcase

        // Queries see the updated status; one-shot latch only without stick mode
        result.pressed_flag = 1'b0;
        unique case (nxt.status)
            ST_NEG_PRESSED, ST_POS_PRESSED: begin
                if (!nxt.signal_sent) begin
                    result.pressed_flag = 1'b1;
                    if (!cfg.stick_mode) begin
                        nxt.signal_sent = 1'b1;
                    end
                end
            end
            ST_NEG_REPEATED, ST_POS_REPEATED: result.pressed_flag = 1'b1;
            default: ;
        endcase

        result.released_flag = (nxt.status == ST_NEUTRAL) || (nxt.status == ST_RELEASED);
        result.axis_value    = nxt.value;
        result.axis_status   = nxt.status;
    end

endmodule

// ===== hw/rtl/dagr_checker.sv =====
// Port-level checks on the result stream of the axis block, bound to the top.
`timescale 1ns / 1ps

module dagr_checker
    import dagr_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic signed [VALUE_W-1:0] value;
    axis_status_t              status;
    logic                      pressed;
    logic                      released;

    assign value    = m_tdata[15:0];
    assign status   = axis_status_t'(m_tdata[18:16]);
    assign pressed  = m_tdata[19];
    assign released = m_tdata[20];

    // Output handshake: a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_neutral_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == ST_NEUTRAL |-> value == '0)
        else $error("neutral status with nonzero value");

    a_held_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == ST_NEG_PRESSED || status == ST_NEG_REPEATED) |->
            value == AXIS_NEG_ONE)
        else $error("negative key held without full scale");

    a_released_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> released == (status == ST_NEUTRAL || status == ST_RELEASED))
        else $error("released flag does not match status");

    a_pressed_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && pressed |-> !released)
        else $error("pressed flag in a released status");

endmodule

bind digital_axis_with_gravity_return dagr_checker u_dagr_checker (.*);

// ===== sim/digital_axis_with_gravity_return_tb.sv =====
// Self-checking testbench for the digital axis with gravity return.
`timescale 1ns / 1ps

module digital_axis_with_gravity_return_tb;
    import dagr_pkg::*;

    typedef enum {
        GAP_NONE,
        GAP_SRC,
        GAP_SINK,
        GAP_BOTH,
        GAP_HOLD
    } gap_mode_t;

    localparam int HOLD_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 105;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DAT_W-1:0]   cfg_data = '0;

    digital_axis_with_gravity_return DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tick_t     tick_q[$];
    result_t   axis_expect_q[$];
    gap_mode_t gap_mode = GAP_NONE;
    int        hold_cnt = 0;
    int        err_count = 0;
    int        n_queued = 0;

    // Shadow of the axis state and its registers
    axis_status_t         axis_st = ST_NEUTRAL;
    int                   axis_val = 0;
    bit                   shot_sent = 1'b0;
    logic [GRAVITY_W-1:0] grav_rate = '0;
    logic [DZONE_W-1:0]   dz_mag = '0;
    bit                   stick_on = 1'b0;
    bit                   neg_bound = 1'b1;
    bit                   pos_bound = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void gravity_decay(input logic [DT_W-1:0] dt);
        int dec;
        int dz;
        dec = int'((32'(grav_rate) * 32'(dt)) >> 2);
        dz = int'(dz_mag);
        shot_sent = 1'b0;
        if (axis_val < 0) begin
            axis_val += dec;
            if (axis_val >= -dz) begin
                axis_val = 0;
                axis_st = ST_NEUTRAL;
            end
        end else begin
            axis_val -= dec;
            if (axis_val <= dz) begin
                axis_val = 0;
                axis_st = ST_NEUTRAL;
            end
        end
    endfunction

    function automatic void snap_axis(input axis_status_t st, input int val);
        axis_st = st;
        axis_val = val;
    endfunction

    function automatic result_t axis_tick(input key_level_t nk, input key_level_t pk,
                                          input logic [DT_W-1:0] dt);
        result_t r;
        bit neg_press;
        bit pos_press;
        bit pressed;
        neg_press = neg_bound && nk == LVL_PRESSED;
        pos_press = pos_bound && pk == LVL_PRESSED;
        case (axis_st)
            ST_RELEASED, ST_NEUTRAL: begin
                if (axis_st == ST_RELEASED)
                    gravity_decay(dt);
                if (neg_press)
                    snap_axis(ST_NEG_PRESSED, int'(AXIS_NEG_ONE));
                else if (pos_press)
                    snap_axis(ST_POS_PRESSED, int'(AXIS_POS_ONE));
            end
            ST_NEG_PRESSED: begin
                if (pos_press) begin
                    snap_axis(ST_POS_PRESSED, int'(AXIS_POS_ONE));
                end else if (neg_bound) begin
                    if (stick_on && nk == LVL_REPEATED) begin
                        snap_axis(ST_NEG_REPEATED, int'(AXIS_NEG_ONE));
                    end else if (nk == LVL_RELEASED) begin
                        axis_st = ST_RELEASED;
                        gravity_decay(dt);
                    end
                end
            end
            ST_POS_PRESSED: begin
                if (neg_press) begin
                    snap_axis(ST_NEG_PRESSED, int'(AXIS_NEG_ONE));
                end else if (pos_bound) begin
                    if (stick_on && pk == LVL_REPEATED) begin
                        snap_axis(ST_POS_REPEATED, int'(AXIS_POS_ONE));
                    end else if (pk == LVL_RELEASED) begin
                        axis_st = ST_RELEASED;
                        gravity_decay(dt);
                    end
                end
            end
            ST_POS_REPEATED: begin
                if (neg_press) begin
                    snap_axis(ST_NEG_PRESSED, int'(AXIS_NEG_ONE));
                end else if (pos_bound && pk == LVL_RELEASED) begin
                    axis_st = ST_RELEASED;
                    gravity_decay(dt);
                end
            end
            ST_NEG_REPEATED: begin
                if (pos_press) begin
                    snap_axis(ST_POS_PRESSED, int'(AXIS_POS_ONE));
                end else if (neg_bound && nk == LVL_RELEASED) begin
                    axis_st = ST_RELEASED;
                    gravity_decay(dt);
                end
            end
            default: ;
        endcase

        // Pressed query after the update; one-shot unless stick mode
        case (axis_st)
            ST_NEG_PRESSED, ST_POS_PRESSED: begin
                pressed = !shot_sent;
                if (!shot_sent && !stick_on)
                    shot_sent = 1'b1;
            end
            ST_NEG_REPEATED, ST_POS_REPEATED: pressed = 1'b1;
            default: pressed = 1'b0;
        endcase

        r.axis_value = axis_val[VALUE_W-1:0];
        r.axis_status = axis_st;
        r.pressed_flag = pressed;
        r.released_flag = (axis_st == ST_NEUTRAL || axis_st == ST_RELEASED);
        return r;
    endfunction

    // Input driver: predicts on each accepted transfer, then offers the next tick
    always @(posedge aclk) begin : tick_feed
        tick_t nxt;
        bit    idle;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                axis_expect_q.push_back(axis_tick(key_level_t'(s_tdata[1:0]),
                                                  key_level_t'(s_tdata[3:2]),
                                                  s_tdata[19:4]));
            if (!s_tvalid || s_tready) begin
                idle = (gap_mode == GAP_SRC && $urandom_range(0, 99) < 72) ||
                       (gap_mode == GAP_BOTH && $urandom_range(0, 99) < 9);
                if (tick_q.size() > 0 && !idle) begin
                    nxt = tick_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, nxt.delta_time, nxt.pos_key_state, nxt.neg_key_state};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge aclk) begin : result_mon
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (axis_expect_q.size() == 0) begin
                $error("result transfer with nothing expected: m_tdata=%h", m_tdata);
                err_count++;
            end else begin
                want = axis_expect_q.pop_front();
                if (m_tdata[15:0] !== want.axis_value) begin
                    $error("axis_value: expected %0d, got %0d",
                           want.axis_value, $signed(m_tdata[15:0]));
                    err_count++;
                end
                if (m_tdata[18:16] !== want.axis_status) begin
                    $error("axis_status: expected %0d, got %0d",
                           want.axis_status, m_tdata[18:16]);
                    err_count++;
                end
                if (m_tdata[19] !== want.pressed_flag) begin
                    $error("pressed_flag: expected %0b, got %0b", want.pressed_flag, m_tdata[19]);
                    err_count++;
                end
                if (m_tdata[20] !== want.released_flag) begin
                    $error("released_flag: expected %0b, got %0b",
                           want.released_flag, m_tdata[20]);
                    err_count++;
                end
            end
        end

        if (gap_mode != GAP_HOLD)
            hold_cnt <= 0;
        if (gap_mode == GAP_HOLD && hold_cnt < HOLD_CYCLES) begin
            // long hold-off so the block fills and stalls its input
            hold_cnt <= hold_cnt + 1;
            m_tready <= 1'b0;
        end else if (gap_mode == GAP_SINK) begin
            m_tready <= $urandom_range(0, 99) >= 72;
        end else if (gap_mode == GAP_BOTH) begin
            m_tready <= $urandom_range(0, 99) >= 9;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic add_tick(input key_level_t nk, input key_level_t pk,
                            input logic [DT_W-1:0] dt);
        tick_t t;
        t.neg_key_state = nk;
        t.pos_key_state = pk;
        t.delta_time = dt;
        tick_q.push_back(t);
        n_queued++;
    endtask

    function automatic logic [DT_W-1:0] rand_dt();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return DT_W'($urandom_range(0, 65535));
            default: return DT_W'($urandom_range(1, 4095));
        endcase
    endfunction

    // One key level on the chosen side, rare noise on the other key
    task automatic add_key(input bit on_neg, input key_level_t lvl);
        key_level_t other;
        other = ($urandom_range(0, 9) == 0) ? key_level_t'($urandom_range(0, 3)) : LVL_NONE;
        if (on_neg)
            add_tick(lvl, other, rand_dt());
        else
            add_tick(other, lvl, rand_dt());
    endtask

    // press, hold or repeat, maybe switch sides, release, then let gravity work
    task automatic add_gesture();
        bit on_neg;
        on_neg = $urandom_range(0, 1);
        add_key(on_neg, LVL_PRESSED);
        repeat ($urandom_range(0, 6))
            add_key(on_neg, $urandom_range(0, 1) ? LVL_REPEATED : LVL_NONE);
        if ($urandom_range(0, 4) == 0) begin
            on_neg = !on_neg;
            add_key(on_neg, LVL_PRESSED);
        end
        add_key(on_neg, LVL_RELEASED);
        repeat ($urandom_range(1, 10))
            add_tick(LVL_NONE, LVL_NONE, rand_dt());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GRAVITY_RATE:  grav_rate = data[GRAVITY_W-1:0];
            CFG_ZERO_BAND:     dz_mag = data[DZONE_W-1:0];
            CFG_STICK_MODE:    stick_on = data[0];
            CFG_NEG_KEY_BOUND: neg_bound = data[0];
            CFG_POS_KEY_BOUND: pos_bound = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (tick_q.size() != 0 || s_tvalid || axis_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [CFG_DAT_W-1:0] grav;
        logic [CFG_DAT_W-1:0] dz;
        case ($urandom_range(0, 5))
            0:       grav = '0;
            1:       grav = 15'd255;
            2:       grav = CFG_DAT_W'($urandom);
            default: grav = CFG_DAT_W'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 5))
            0:       dz = '0;
            1:       dz = 15'd16383;
            2:       dz = CFG_DAT_W'($urandom);
            default: dz = CFG_DAT_W'($urandom_range(0, 2000));
        endcase
        write_reg(CFG_GRAVITY_RATE, grav);
        write_reg(CFG_ZERO_BAND, dz);
        write_reg(CFG_STICK_MODE, CFG_DAT_W'($urandom));
        write_reg(CFG_NEG_KEY_BOUND, ($urandom_range(0, 5) != 0) ? 15'd1 : 15'd0);
        write_reg(CFG_POS_KEY_BOUND, ($urandom_range(0, 5) != 0) ? 15'd1 : 15'd0);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_POS_KEY_BOUND + CFG_IDX_W'($urandom_range(1, 3)),
                      CFG_DAT_W'($urandom));
    endtask

    initial begin : stimulus
        gap_mode_t phase_gap[6];
        int target;
        phase_gap = '{GAP_NONE, GAP_SRC, GAP_SINK, GAP_BOTH, GAP_HOLD, GAP_BOTH};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one-shot press, repeat ignored, side switch, no decay
        add_tick(LVL_NONE, LVL_NONE, 16'd0);
        add_tick(LVL_PRESSED, LVL_NONE, 16'd0);
        add_tick(LVL_NONE, LVL_NONE, 16'd0);
        add_tick(LVL_REPEATED, LVL_NONE, 16'd0);
        add_tick(LVL_NONE, LVL_PRESSED, 16'd0);
        add_tick(LVL_NONE, LVL_RELEASED, 16'hFFFF);
        add_tick(LVL_NONE, LVL_NONE, 16'hFFFF);
        add_tick(LVL_PRESSED, LVL_PRESSED, 16'd0);
        add_tick(LVL_RELEASED, LVL_NONE, 16'd0);
        drain();

        // gravity written out of range (masked), zero band just under full scale, stick mode, unmapped write
        write_reg(CFG_GRAVITY_RATE, 15'h7FFF);
        write_reg(CFG_ZERO_BAND, 15'd16383);
        write_reg(CFG_STICK_MODE, 15'd1);
        write_reg(CFG_POS_KEY_BOUND + 3'd1, 15'h7FFF);
        gap_mode = GAP_BOTH;
        add_tick(LVL_NONE, LVL_NONE, 16'd0);
        add_tick(LVL_NONE, LVL_NONE, 16'd1);
        add_tick(LVL_NONE, LVL_PRESSED, 16'd0);
        add_tick(LVL_NONE, LVL_NONE, 16'd0);
        add_tick(LVL_NONE, LVL_REPEATED, 16'd0);
        add_tick(LVL_PRESSED, LVL_REPEATED, 16'd0);
        add_tick(LVL_REPEATED, LVL_NONE, 16'd0);
        add_tick(LVL_RELEASED, LVL_NONE, 16'hFFFF);
        drain();

        // negative key unbound
        write_reg(CFG_NEG_KEY_BOUND, 15'd0);
        add_tick(LVL_PRESSED, LVL_NONE, 16'd0);
        add_tick(LVL_PRESSED, LVL_PRESSED, 16'd0);
        add_tick(LVL_PRESSED, LVL_RELEASED, 16'd0);
        add_tick(LVL_REPEATED, LVL_REPEATED, 16'd0);
        drain();

        // positive key unbound, no gravity, no zero band
        write_reg(CFG_POS_KEY_BOUND, 15'd0);
        write_reg(CFG_NEG_KEY_BOUND, 15'd1);
        write_reg(CFG_GRAVITY_RATE, 15'd0);
        write_reg(CFG_ZERO_BAND, 15'd0);
        add_tick(LVL_PRESSED, LVL_PRESSED, 16'd0);
        add_tick(LVL_RELEASED, LVL_PRESSED, 16'd0);
        add_tick(LVL_NONE, LVL_PRESSED, 16'hFFFF);
        drain();

        for (int p = 0; p < 6; p++) begin
            random_config();
            gap_mode = phase_gap[p];
            target = n_queued + ITEMS_PER_PHASE;
            while (n_queued < target) begin
                if ($urandom_range(0, 4) == 0)
                    add_tick(key_level_t'($urandom_range(0, 3)),
                             key_level_t'($urandom_range(0, 3)), rand_dt());
                else
                    add_gesture();
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== digital_axis_with_gravity_return.f =====
hw/rtl/dagr_pkg.sv
hw/rtl/dagr_cfg_regs.sv
hw/rtl/dagr_tick.sv
hw/rtl/digital_axis_with_gravity_return.sv
hw/rtl/dagr_checker.sv
sim/digital_axis_with_gravity_return_tb.sv
